// ----- rtl/sspc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse set unit package
// Shared widths, action and register codes, word types and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sspc_pkg;

    // Default number of table entries
    localparam int MAX_CAPACITY_DEF = 64;

    // Field widths
    localparam int ACTION_W   = 3;
    localparam int ELEMENT_W  = 6;
    localparam int POSITION_W = 6;
    localparam int ANSWER_W   = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_AT_POS   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POS_OF   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MEMBER   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT    = 2'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] CAPACITY_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] PIVOT_RST    = 7'd0;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [ELEMENT_W-1:0]  element;
        logic [POSITION_W-1:0] position;
    } sspc_in_t;

    typedef struct packed {
        logic [ANSWER_W-1:0] answer;
        logic                found;
        logic                is_member;
        logic [COUNT_W-1:0]  member_count;
        logic [COUNT_W-1:0]  high_count;
    } sspc_out_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic rd;
        logic eval;
        logic swap;
        logic clr_begin;
        logic clr_step;
        logic emit;
    } sspc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic do_update;
        logic clr_last;
        logic out_free;
    } sspc_sts_t;

endpackage
`default_nettype wire

// ----- rtl/sspc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sspc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/sspc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse set controller
// Sequences the table sweep, the read, evaluate and swap steps of one word,
// and the hand-off of the result word.
// ----------------------------------------------------------------------------
module sspc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sspc_pkg::sspc_sts_t  sts,
    output sspc_pkg::sspc_cmd_t       cmd
);
    import sspc_pkg::*;

    localparam logic [2:0] ST_BOOT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_SWAP  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts the identity sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_BOOT: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd = 1'b1;
                if (sts.is_clear) begin
                    cmd.clr_begin = 1'b1;
                    state_next    = ST_CLEAR;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.do_update ? ST_SWAP : ST_DONE;
            end
            ST_SWAP: begin
                cmd.swap   = 1'b1;
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_BOOT;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/sspc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse set datapath
// Holds the configuration, the counters, the dense order and position
// tables, and the result word register.
// ----------------------------------------------------------------------------
module sspc_dp #(
    parameter int MAX_CAPACITY = sspc_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire sspc_pkg::sspc_cmd_t                 cmd,
    output sspc_pkg::sspc_sts_t                      sts,
    input  wire sspc_pkg::sspc_in_t                  s_data,
    input  wire logic                                cfg_valid,
    input  wire logic [sspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sspc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                m_ready,
    output logic                                     m_valid,
    output sspc_pkg::sspc_out_t                      m_data
);
    import sspc_pkg::*;

    localparam int AW = $clog2(MAX_CAPACITY);
    localparam int CW = $clog2(MAX_CAPACITY + 1);

    sspc_in_t              in_reg;
    logic [CFG_DATA_W-1:0] cap_reg;
    logic [CFG_DATA_W-1:0] pivot_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         above_reg;
    logic [CW-1:0]         above_next;
    logic [AW-1:0]         p_reg;
    logic [AW-1:0]         x_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic [ANSWER_W-1:0]   answer_reg;
    logic [ANSWER_W-1:0]   answer_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  member_reg;
    logic                  m_valid_reg;
    sspc_out_t             m_data_reg;

    logic          dense_we, pos_we;
    logic [AW-1:0] dense_waddr, dense_wdata, pos_waddr, pos_wdata;
    logic [AW-1:0] dense_raddr, pos_raddr;
    logic [AW-1:0] dense_rdata, pos_rdata;

    logic          elem_ok;
    logic          member_before;
    logic          is_ins;
    logic          ins_go;
    logic          rem_go;
    logic          elem_high;
    logic [AW-1:0] slot;
    logic [AW-1:0] elem_addr;

    // Decode the word under work
    always_comb begin
        elem_addr     = AW'(in_reg.element);
        elem_ok       = ({1'b0, in_reg.element} < cap_reg)
                        && (32'(in_reg.element) < 32'(MAX_CAPACITY));
        member_before = elem_ok && (32'(pos_rdata) < 32'(count_reg));
        is_ins        = in_reg.action == ACT_INSERT;
        ins_go        = is_ins && elem_ok && !member_before
                        && (32'(count_reg) < 32'(MAX_CAPACITY));
        rem_go        = (in_reg.action == ACT_REMOVE) && member_before;
        elem_high     = {1'b0, in_reg.element} >= pivot_reg;
        slot          = is_ins ? AW'(count_reg) : AW'(count_reg - 1'b1);
    end

    // Query answer for the word under work; zero when nothing is found
    always_comb begin
        answer_next = '0;
        found_next  = 1'b0;
        if (in_reg.action == ACT_AT_POS) begin
            if (32'(in_reg.position) < 32'(count_reg)) begin
                answer_next = ANSWER_W'(dense_rdata);
                found_next  = 1'b1;
            end
        end else if (in_reg.action == ACT_POS_OF) begin
            if (member_before) begin
                answer_next = ANSWER_W'(pos_rdata);
                found_next  = 1'b1;
            end
        end
    end

    // Status to the controller
    always_comb begin
        sts.is_clear  = in_reg.action == ACT_CLEAR;
        sts.do_update = ins_go || rem_go;
        sts.clr_last  = clr_idx_reg == AW'(MAX_CAPACITY - 1);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // Table reads: position of the element, and element at a dense slot
    assign pos_raddr   = elem_addr;
    assign dense_raddr = (in_reg.action == ACT_AT_POS) ? AW'(in_reg.position) : slot;

    // Table writes: identity sweep, first half of the swap, second half
    always_comb begin
        dense_we    = 1'b0;
        dense_waddr = clr_idx_reg;
        dense_wdata = clr_idx_reg;
        pos_we      = 1'b0;
        pos_waddr   = clr_idx_reg;
        pos_wdata   = clr_idx_reg;
        if (cmd.clr_step) begin
            dense_we = 1'b1;
            pos_we   = 1'b1;
        end else if (cmd.eval && (ins_go || rem_go)) begin
            dense_we    = 1'b1;
            dense_waddr = slot;
            dense_wdata = elem_addr;
            pos_we      = 1'b1;
            pos_waddr   = elem_addr;
            pos_wdata   = slot;
        end else if (cmd.swap) begin
            dense_we    = 1'b1;
            dense_waddr = p_reg;
            dense_wdata = x_reg;
            pos_we      = 1'b1;
            pos_waddr   = x_reg;
            pos_wdata   = p_reg;
        end
    end

    sspc_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_CAPACITY)
    ) u_dense_ram (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .re    (cmd.rd),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    sspc_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_CAPACITY)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (cmd.rd),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Member and pivot counters, saturating as the set allows
    always_comb begin
        count_next = count_reg;
        above_next = above_reg;
        if (cmd.clr_begin) begin
            count_next = '0;
            above_next = '0;
        end else if (cmd.eval && ins_go) begin
            count_next = count_reg + 1'b1;
            if (elem_high && (32'(above_reg) < 32'(MAX_CAPACITY))) begin
                above_next = above_reg + 1'b1;
            end
        end else if (cmd.eval && rem_go) begin
            count_next = count_reg - 1'b1;
            if (elem_high && (above_reg != '0)) begin
                above_next = above_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAPACITY_RST;
            pivot_reg   <= PIVOT_RST;
            count_reg   <= '0;
            above_reg   <= '0;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_CAPACITY: cap_reg   <= cfg_data;
                    CFG_PIVOT:    pivot_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            count_reg <= count_next;
            above_reg <= above_next;
            if (cmd.clr_step) begin
                clr_idx_reg <= sts.clr_last ? '0 : clr_idx_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input word, swap operands, result fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            in_reg <= s_data;
        end
        if (cmd.eval) begin
            p_reg      <= pos_rdata;
            x_reg      <= dense_rdata;
            answer_reg <= answer_next;
            found_reg  <= found_next;
            member_reg <= ins_go ? 1'b1 : (rem_go ? 1'b0 : member_before);
        end else if (cmd.clr_begin) begin
            answer_reg <= '0;
            found_reg  <= 1'b0;
            member_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_data_reg.answer       <= answer_reg;
            m_data_reg.found        <= found_reg;
            m_data_reg.is_member    <= member_reg;
            m_data_reg.member_count <= COUNT_W'(count_reg);
            m_data_reg.high_count   <= COUNT_W'(above_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/sparse_set_with_pivot_count_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse set with pivot count
// Set of element numbers kept in a dense order table and a position table.
// ----------------------------------------------------------------------------
// Usage:
//  - s_valid/s_ready/s_data carry one request word: action, element,
//    position. m_valid/m_ready/m_data carry one result word per request.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write capacity (index 0) and
//    pivot (index 1); cfg_ready is always high. Write only while idle.
//  - Sequence: an accepted word is latched, then the tables are read and
//    the word is evaluated (a clear word sweeps the tables instead); an
//    insert or remove that changes the set adds a swap state for the second
//    half of the swap. The result word is registered once the output is free.
//  - A new word is taken only once the last result word is registered;
//    both tables have one write port, and a swap writes two entries in each.
//  - Clear sweeps all MAX_CAPACITY table entries, one per cycle.
//  - Reset: synchronous, active low. After reset the tables are swept to
//    identity with s_ready low; config writes are taken during the sweep.
//  - A stalled result word is held in the output register; the next request
//    is still accepted and worked up to the point where its result is due.
// ----------------------------------------------------------------------------
module sparse_set_with_pivot_count_unit #(
    parameter int MAX_CAPACITY = sspc_pkg::MAX_CAPACITY_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire sspc_pkg::sspc_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output sspc_pkg::sspc_out_t                   m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sspc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sspc_pkg::*;

    sspc_cmd_t cmd;
    sspc_sts_t sts;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    sspc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sspc_dp #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ----- rtl/sspc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse set port checker
// Watches the top level ports for handshake and result word consistency.
// ----------------------------------------------------------------------------
module sspc_checker #(
    parameter int MAX_CAPACITY = sspc_pkg::MAX_CAPACITY_DEF
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire sspc_pkg::sspc_out_t              m_data
);
    import sspc_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Drop ready after taking a request word
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in work");

    // Zero answer when nothing was found
    a_answer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.answer == '0)
        else $error("answer nonzero without found");

    // A member implies a nonempty set
    a_member_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.found || m_data.is_member) && (MAX_CAPACITY < 128)
        |-> m_data.member_count != '0)
        else $error("member reported in an empty set");

endmodule

bind sparse_set_with_pivot_count_unit sspc_checker #(
    .MAX_CAPACITY (MAX_CAPACITY)
) u_sspc_checker (.*);
`default_nettype wire

// ----- test/sparse_set_with_pivot_count_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse set with pivot count - block level testbench
// A driver streams request words from a queue and a monitor checks every
// result word against an in-bench model of the sparse set tables, the member
// count and the pivot tally. Capacity and pivot change between phases, both
// handshakes idle at random, and the receiver holds off once for a long run.
// ----------------------------------------------------------------------------
module sparse_set_with_pivot_count_unit_tb;

    import sspc_pkg::*;

    localparam int SET_DEPTH   = MAX_CAPACITY_DEF;
    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_GAP    = 8;
    localparam int PRINT_MAX   = 100;

    // Codes outside the defined action and register sets
    localparam logic [ACTION_W-1:0]  ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0]  ACT_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sspc_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sspc_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    sparse_set_with_pivot_count_unit #(
        .MAX_CAPACITY(SET_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Request words waiting to be sent, status words waiting to arrive
    sspc_in_t  op_queue[$];
    sspc_out_t status_due[$];

    int sent_words     = 0;
    int accepted_words = 0;
    int cfg_writes     = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 35;
    int snk_idle_pct   = 35;
    int stall_requests = 0;
    int stall_served   = 0;
    int hold_left      = 0;
    int elem_span      = 63;

    // Model state: membership, dense order, inverse positions, tallies
    logic                  member_bit [SET_DEPTH];
    logic [ELEMENT_W-1:0]  dense_tab  [SET_DEPTH];
    logic [POSITION_W-1:0] slot_of    [SET_DEPTH];
    logic [COUNT_W-1:0]    set_size;
    logic [COUNT_W-1:0]    high_tally;
    logic [CFG_DATA_W-1:0] cap_reg;
    logic [CFG_DATA_W-1:0] piv_reg;
    sspc_out_t             due_word;

    task automatic flag_error(input string msg);
        if (error_count < PRINT_MAX)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void wipe_set();
        for (int i = 0; i < SET_DEPTH; i++) begin
            member_bit[i] = 1'b0;
            dense_tab[i]  = ELEMENT_W'(i);
            slot_of[i]    = POSITION_W'(i);
        end
        set_size   = '0;
        high_tally = '0;
    endfunction

    // Exchange two dense slots and repair the position table
    function automatic void swap_slots(input logic [5:0] a, input logic [5:0] b);
        logic [ELEMENT_W-1:0] ea;
        logic [ELEMENT_W-1:0] eb;
        ea = dense_tab[a];
        eb = dense_tab[b];
        dense_tab[a] = eb;
        dense_tab[b] = ea;
        slot_of[ea]  = b;
        slot_of[eb]  = a;
    endfunction

    // Apply one request to the model and return the status word it yields
    function automatic sspc_out_t predict_status(input sspc_in_t req);
        sspc_out_t          res;
        int                 lim;
        logic               hit;
        logic [COUNT_W-1:0] last;
        lim = (cap_reg > SET_DEPTH) ? SET_DEPTH : int'(cap_reg);
        hit = (int'(req.element) < lim);
        res = '0;
        case (req.action)
            ACT_INSERT: begin
                if (hit && !member_bit[req.element] && set_size < SET_DEPTH) begin
                    if ({1'b0, req.element} >= piv_reg && high_tally < SET_DEPTH)
                        high_tally++;
                    swap_slots(set_size[5:0], slot_of[req.element]);
                    member_bit[req.element] = 1'b1;
                    set_size++;
                end
            end
            ACT_REMOVE: begin
                if (hit && member_bit[req.element] && set_size > 0) begin
                    if ({1'b0, req.element} >= piv_reg && high_tally > 0)
                        high_tally--;
                    last = set_size - 7'd1;
                    swap_slots(last[5:0], slot_of[req.element]);
                    member_bit[req.element] = 1'b0;
                    set_size--;
                end
            end
            ACT_AT_POS: begin
                if ({1'b0, req.position} < set_size) begin
                    res.answer = dense_tab[req.position];
                    res.found  = 1'b1;
                end
            end
            ACT_POS_OF: begin
                if (hit && member_bit[req.element]) begin
                    res.answer = slot_of[req.element];
                    res.found  = 1'b1;
                end
            end
            ACT_CLEAR: wipe_set();
            default: ;
        endcase
        res.is_member    = hit && member_bit[req.element];
        res.member_count = set_size;
        res.high_count   = high_tally;
        return res;
    endfunction

    // Monitor: track config writes, check result words, predict accepted words
    always @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg = CAPACITY_RST;
            piv_reg = PIVOT_RST;
            wipe_set();
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CAPACITY: cap_reg = cfg_data;
                    CFG_PIVOT:    piv_reg = cfg_data;
                    default: ;
                endcase
                cfg_writes++;
            end
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    flag_error("result word with nothing expected");
                end else begin
                    due_word = status_due.pop_front();
                    if (m_data.answer !== due_word.answer)
                        flag_error($sformatf("answer %0d, want %0d",
                                             m_data.answer, due_word.answer));
                    if (m_data.found !== due_word.found)
                        flag_error($sformatf("found %0b, want %0b",
                                             m_data.found, due_word.found));
                    if (m_data.is_member !== due_word.is_member)
                        flag_error($sformatf("is_member %0b, want %0b",
                                             m_data.is_member, due_word.is_member));
                    if (m_data.member_count !== due_word.member_count)
                        flag_error($sformatf("member_count %0d, want %0d",
                                             m_data.member_count, due_word.member_count));
                    if (m_data.high_count !== due_word.high_count)
                        flag_error($sformatf("high_count %0d, want %0d",
                                             m_data.high_count, due_word.high_count));
                end
            end
            if (s_valid && s_ready) begin
                status_due.push_back(predict_status(s_data));
                accepted_words++;
            end
        end
    end

    // Driver: hold the offered word until taken, then send the next or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && accepted_words != sent_words) begin
            s_valid <= 1'b1;
        end else if (op_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            s_data  <= op_queue.pop_front();
            s_valid <= 1'b1;
            sent_words++;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("sparse_set_with_pivot_count_unit verification failed");
            $finish;
        end
    end

    task automatic push_op(input logic [ACTION_W-1:0] act,
                           input logic [ELEMENT_W-1:0] elem,
                           input logic [POSITION_W-1:0] pos);
        sspc_in_t w;
        w.action   = act;
        w.element  = elem;
        w.position = pos;
        op_queue.push_back(w);
    endtask

    // Offer one register write and drop it at the falling edge after it is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int target;
        target = cfg_writes + 1;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (cfg_writes != target)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: let every outstanding word come back, then settle
    task automatic wait_idle();
        while (op_queue.size() != 0 || accepted_words != sent_words ||
               status_due.size() != 0)
            @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic start_phase(input logic [CFG_DATA_W-1:0] cap,
                               input logic [CFG_DATA_W-1:0] piv);
        wait_idle();
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_PIVOT, piv);
        elem_span = (cap > 63) ? 63 : ((cap == 0) ? 1 : int'(cap));
    endtask

    // Mostly set updates and queries near the capacity, some pure noise
    task automatic queue_random(input int n);
        sspc_in_t w;
        int       pick;
        for (int i = 0; i < n; i++) begin
            pick       = $urandom_range(0, 99);
            w.element  = ($urandom_range(0, 99) < 10)
                         ? ELEMENT_W'($urandom_range(0, 63))
                         : ELEMENT_W'($urandom_range(0, elem_span));
            w.position = ($urandom_range(0, 99) < 20)
                         ? POSITION_W'($urandom_range(0, 63))
                         : POSITION_W'($urandom_range(0, elem_span));
            if (pick < 32)      w.action = ACT_INSERT;
            else if (pick < 52) w.action = ACT_REMOVE;
            else if (pick < 64) w.action = ACT_AT_POS;
            else if (pick < 76) w.action = ACT_POS_OF;
            else if (pick < 88) w.action = ACT_MEMBER;
            else if (pick < 90) w.action = ACT_CLEAR;
            else                w.action = ACTION_W'($urandom_range(0, 7));
            op_queue.push_back(w);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at reset configuration
        push_op(ACT_MEMBER, 6'd0, 6'd0);
        push_op(ACT_AT_POS, 6'd0, 6'd0);
        push_op(ACT_POS_OF, 6'd63, 6'd0);
        push_op(ACT_INSERT, 6'd0, 6'd0);
        push_op(ACT_INSERT, 6'd63, 6'd0);
        push_op(ACT_INSERT, 6'd0, 6'd0);
        push_op(ACT_INSERT, 6'd31, 6'd0);
        push_op(ACT_AT_POS, 6'd0, 6'd0);
        push_op(ACT_AT_POS, 6'd0, 6'd2);
        push_op(ACT_AT_POS, 6'd0, 6'd3);
        push_op(ACT_AT_POS, 6'd0, 6'd63);
        push_op(ACT_POS_OF, 6'd63, 6'd0);
        push_op(ACT_POS_OF, 6'd0, 6'd0);
        push_op(ACT_REMOVE, 6'd0, 6'd0);
        push_op(ACT_REMOVE, 6'd0, 6'd0);
        push_op(ACT_AT_POS, 6'd0, 6'd0);
        push_op(ACT_SPARE_6, 6'd63, 6'd63);
        push_op(ACT_SPARE_7, 6'd31, 6'd0);
        push_op(ACT_MEMBER, 6'd63, 6'd0);
        push_op(ACT_INSERT, 6'd5, 6'd0);
        push_op(ACT_REMOVE, 6'd5, 6'd0);
        push_op(ACT_POS_OF, 6'd5, 6'd0);
        push_op(ACT_CLEAR, 6'd0, 6'd0);
        push_op(ACT_AT_POS, 6'd0, 6'd0);
        push_op(ACT_MEMBER, 6'd63, 6'd0);

        // Smallest capacity, then a capacity that takes nothing
        start_phase(7'd1, 7'd0);
        queue_random(100);
        start_phase(7'd0, 7'd0);
        queue_random(50);

        // Capacity above the table size; unused register slots written too
        start_phase(7'd127, 7'd64);
        write_reg(CFG_SPARE_2, 7'h7F);
        write_reg(CFG_SPARE_3, 7'h00);
        queue_random(180);

        // Long receiver hold-off so the block backs up its input
        start_phase(7'd16, 7'd8);
        stall_requests++;
        queue_random(200);

        // Pivot above every element, then lowered without a clear
        start_phase(7'd64, 7'd127);
        queue_random(150);
        start_phase(7'd64, 7'd32);
        queue_random(150);

        // Capacity lowered below current members
        start_phase(7'd10, 7'd5);
        queue_random(150);

        // Fill the set, drain it past the pivot, refill to saturate the tally
        start_phase(7'd64, 7'd0);
        push_op(ACT_CLEAR, 6'd0, 6'd0);
        for (int i = 0; i < SET_DEPTH; i++)
            push_op(ACT_INSERT, ELEMENT_W'(i), 6'd0);
        push_op(ACT_AT_POS, 6'd0, 6'd63);
        push_op(ACT_INSERT, 6'd10, 6'd0);
        start_phase(7'd64, 7'd127);
        for (int i = SET_DEPTH - 1; i >= 0; i--)
            push_op(ACT_REMOVE, ELEMENT_W'(i), 6'd0);
        start_phase(7'd64, 7'd0);
        for (int i = 0; i < 20; i++)
            push_op(ACT_INSERT, ELEMENT_W'($urandom_range(0, 63)), 6'd0);
        queue_random(80);

        // Stretch with no idling on either side
        start_phase(7'd40, 7'd20);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(200);

        start_phase(7'd64, 7'd0);
        src_idle_pct = 35;
        snk_idle_pct = 35;
        queue_random(120);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("sparse_set_with_pivot_count_unit verification clean");
        else
            $display("sparse_set_with_pivot_count_unit verification failed");
        $finish;
    end

endmodule
